/* hw/rtl/a2i_pkg.sv */
// shared types, character codes, status codes and digit decode for the ascii to integer converter
package a2i_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned RadixW  = 6;
	localparam int unsigned DigitW  = 7;
	localparam int unsigned StatusW = 2;
	localparam int unsigned ValueW  = 64;
	localparam int unsigned OffsetW = 32;
	localparam int unsigned OutDataW = 104;

	typedef logic [CharW-1:0]   char_t;
	typedef logic [RadixW-1:0]  radix_t;
	typedef logic [DigitW-1:0]  digit_t;
	typedef logic [StatusW-1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_DIGITS = 2'd1;
	localparam status_t ST_RANGE     = 2'd2;
	localparam status_t ST_BAD_BASE  = 2'd3;

	localparam radix_t RADIX_RESET = 6'd10;
	localparam radix_t RADIX_MAX   = 6'd36;
	localparam radix_t RADIX_ONE   = 6'd1;
	localparam radix_t RADIX_AUTO  = 6'd0;
	localparam radix_t RADIX_OCT   = 6'd8;
	localparam radix_t RADIX_DEC   = 6'd10;
	localparam radix_t RADIX_HEX   = 6'd16;
	localparam radix_t RADIX_MIN   = 6'd2;

	localparam char_t CH_SPACE = 8'd32;
	localparam char_t CH_TAB   = 8'd9;
	localparam char_t CH_CR    = 8'd13;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_LC_A  = 8'h61;
	localparam char_t CH_LC_Z  = 8'h7A;
	localparam char_t CH_UC_A  = 8'h41;
	localparam char_t CH_UC_Z  = 8'h5A;
	localparam char_t CH_LC_X  = 8'h78;
	localparam char_t CH_UC_X  = 8'h58;

	localparam digit_t NOT_A_DIGIT = 7'd99;
	localparam digit_t DIGIT_TEN   = 7'd10;

	// digit value of a character, letters counting 10 to 35
	function automatic digit_t digit_of(input char_t ch);
		digit_t d;
		begin
			d = NOT_A_DIGIT;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				d = DigitW'(ch - CH_ZERO);
			end else if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
				d = DigitW'(ch - CH_LC_A) + DIGIT_TEN;
			end else if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
				d = DigitW'(ch - CH_UC_A) + DIGIT_TEN;
			end
			return d;
		end
	endfunction

endpackage

/* hw/rtl/ascii_to_signed_integer.sv */
// streaming ascii to signed integer converter, one character per transfer
// result: m_tvalid rises in the cycle after the transfer of the character that ends
//   the number (or of a start character with an invalid radix)
// throughput: one character per cycle unless a held result stalls s_tready; the 6-bit radix
//   multiply and add into the accumulator is the longest path
// reset: arst_n clears the parse state to idle, empties the output register, radix becomes 10
module ascii_to_signed_integer
	import a2i_pkg::*;
#(
	parameter int unsigned VALUE_BITS  = 64,
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: radix register
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [RadixW-1:0]   cfg_data,
	// character stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CharW-1:0]    s_tdata,   // [7:0] character
	input  logic                s_tuser,   // [0] start_req
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata    // [63:0] value, [95:64] end_offset, [97:96] status
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_FIRST,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	localparam int unsigned MulW = VALUE_BITS + RadixW;

	// signed limits of the accumulator width
	localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] SMAX = ~SMIN;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;

	// parse state
	phase_t                  phase_q;
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic                    ovf_q;
	radix_t                  base_q;
	logic [OFFSET_BITS-1:0]  pos_q;
	logic [OFFSET_BITS-1:0]  nstart_q;
	radix_t                  radix_q;

	// output register
	logic                    out_valid_q;
	logic [VALUE_BITS-1:0]   out_val_q;
	logic [OFFSET_BITS-1:0]  out_off_q;
	status_t                 out_st_q;

	// next state of one character
	phase_t                  ph;
	logic                    neg;
	logic [VALUE_BITS-1:0]   acc;
	logic                    ovf;
	radix_t                  base;
	logic [OFFSET_BITS-1:0]  pos;
	logic [OFFSET_BITS-1:0]  nstart;
	logic                    fin;
	logic                    do_acc;
	logic                    emit;
	logic [VALUE_BITS-1:0]   res_val;
	logic [OFFSET_BITS-1:0]  res_off;
	status_t                 res_st;
	logic [MulW-1:0]         prod;

	char_t                   ch;
	digit_t                  dig;
	logic                    accept;
	logic                    is_space;

	assign ch       = s_tdata;
	assign dig      = digit_of(ch);
	assign is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

	// single output stage: take a character whenever the result slot is free or draining
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_st_q, OffsetW'(out_off_q), ValueW'($signed(out_val_q))};

	// one character through the parser, following the phase fall-through
	always_comb begin
		ph      = phase_q;
		neg     = neg_q;
		acc     = acc_q;
		ovf     = ovf_q;
		base    = base_q;
		pos     = pos_q;
		nstart  = nstart_q;
		fin     = 1'b0;
		do_acc  = 1'b0;
		emit    = 1'b0;
		res_val = '0;
		res_off = '0;
		res_st  = ST_OK;
		prod    = '0;

		// start clears the string state, the radix is latched here
		if (s_tuser) begin
			neg    = 1'b0;
			acc    = '0;
			ovf    = 1'b0;
			pos    = '0;
			nstart = '0;
			base   = radix_q;
			if (base == RADIX_ONE || base > RADIX_MAX) begin
				emit   = 1'b1;
				res_st = ST_BAD_BASE;
				ph     = PH_IDLE;
				fin    = 1'b1;
			end else begin
				ph = PH_SPACE;
			end
		end

		if (!fin && ph == PH_IDLE) begin
			fin = 1'b1;
		end

		// leading whitespace, then an optional sign
		if (!fin && ph == PH_SPACE) begin
			if (is_space) begin
				if (pos != OMAX) pos = pos + 1'b1;
				fin = 1'b1;
			end else begin
				nstart = pos;
				ph     = PH_FIRST;
				if (ch == CH_PLUS || ch == CH_MINUS) begin
					neg = (ch == CH_MINUS);
					if (pos != OMAX) pos = pos + 1'b1;
					fin = 1'b1;
				end
			end
		end

		// first character of the number proper
		if (!fin && ph == PH_FIRST) begin
			if (ch == CH_ZERO && (base == RADIX_AUTO || base == RADIX_HEX)) begin
				if (pos != OMAX) pos = pos + 1'b1;
				ph  = PH_ZERO;
				fin = 1'b1;
			end else begin
				if (base == RADIX_AUTO) base = RADIX_DEC;
				if (dig < DigitW'(base)) begin
					do_acc = 1'b1;
					ph     = PH_DIGITS;
				end else begin
					emit    = 1'b1;
					res_off = nstart;
					res_st  = ST_NO_DIGITS;
					ph      = PH_IDLE;
				end
				fin = 1'b1;
			end
		end

		// leading zero: hex prefix or octal in auto mode
		if (!fin && ph == PH_ZERO) begin
			if (ch == CH_LC_X || ch == CH_UC_X) begin
				if (pos != OMAX) pos = pos + 1'b1;
				ph  = PH_PREFIX;
				fin = 1'b1;
			end else begin
				if (base == RADIX_AUTO) base = RADIX_OCT;
				ph = PH_DIGITS;
			end
		end

		// after the prefix: a hex digit, else the lone zero converts
		if (!fin && ph == PH_PREFIX) begin
			if (dig < DigitW'(RADIX_HEX)) begin
				base   = RADIX_HEX;
				do_acc = 1'b1;
				ph     = PH_DIGITS;
			end else begin
				emit    = 1'b1;
				res_off = (pos != '0) ? pos - 1'b1 : '0;
				res_st  = ST_OK;
				ph      = PH_IDLE;
			end
			fin = 1'b1;
		end

		// digit run, ended by the first character that is no digit of the base
		if (!fin) begin
			if (base >= RADIX_MIN && dig < DigitW'(base)) begin
				do_acc = 1'b1;
			end else begin
				emit    = 1'b1;
				res_off = pos;
				ph      = PH_IDLE;
				if (neg) begin
					if (ovf || (acc[VALUE_BITS-1] && acc[VALUE_BITS-2:0] != '0)) begin
						res_val = SMIN;
						res_st  = ST_RANGE;
					end else begin
						res_val = '0 - acc;
						res_st  = ST_OK;
					end
				end else begin
					if (ovf || acc[VALUE_BITS-1]) begin
						res_val = SMAX;
						res_st  = ST_RANGE;
					end else begin
						res_val = acc;
						res_st  = ST_OK;
					end
				end
			end
		end

		// multiply-add, overflow when the product leaves the accumulator width
		if (do_acc) begin
			prod = MulW'(acc) * MulW'(base) + MulW'(dig);
			if (!ovf) begin
				if (prod[MulW-1:VALUE_BITS] != '0) begin
					ovf = 1'b1;
				end else begin
					acc = prod[VALUE_BITS-1:0];
				end
			end
			if (pos != OMAX) pos = pos + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			base_q      <= '0;
			pos_q       <= '0;
			nstart_q    <= '0;
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_off_q   <= '0;
			out_st_q    <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_data;
			end
			if (accept) begin
				phase_q  <= ph;
				neg_q    <= neg;
				acc_q    <= acc;
				ovf_q    <= ovf;
				base_q   <= base;
				pos_q    <= pos;
				nstart_q <= nstart;
			end
			// result register, loaded on the transfer that completes a number or meets a bad radix
			if (accept && emit) begin
				out_valid_q <= 1'b1;
				out_val_q   <= res_val;
				out_off_q   <= res_off;
				out_st_q    <= res_st;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a saturated result carries one of the two signed limits
	a_range_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q == ST_RANGE) |-> (out_val_q == SMAX || out_val_q == SMIN))
		else $error("range status without a saturated value");

	// no digits or a bad radix always gives a zero value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_st_q == ST_NO_DIGITS || out_st_q == ST_BAD_BASE))
			|-> (out_val_q == '0))
		else $error("nonzero value with no-digit or bad-radix status");

	// a character that completes nothing leaves the result slot only draining
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !emit) |=> (m_tvalid == ($past(m_tvalid) && !$past(m_tready))))
		else $error("result produced without a completing character");

	// every result returns the parser to idle
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a result");

endmodule

/* tb/tb_ascii_to_signed_integer.sv */
// self-checking testbench for the streaming ascii to signed integer converter
module tb_ascii_to_signed_integer
	import a2i_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// pacing of both stream sides
	localparam int unsigned IDLE_PCT       = 30;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned PHASE_ITEMS    = 280;
	localparam int unsigned BAD_BASE_ITEMS = 40;

	// radix settings beyond the legal range
	localparam radix_t RADIX_PAST = 6'd37;
	localparam radix_t RADIX_TOP  = 6'd63;

	// data extremes of one character
	localparam char_t CH_NUL = 8'h00;
	localparam char_t CH_TOP = 8'hFF;

	localparam logic [ValueW-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ValueW-1:0] SMIN = 64'h8000_0000_0000_0000;
	localparam logic [ValueW-1:0] UMAX = '1;

	typedef struct packed {
		logic [ValueW-1:0]  value;
		logic [OffsetW-1:0] offset;
		status_t            status;
	} num_result_t;

	// parser position within one string
	typedef enum logic [2:0] {
		PS_IDLE, PS_SPACE, PS_FIRST, PS_ZERO, PS_PREFIX, PS_DIGITS
	} parse_state_t;

	typedef enum logic {ROW_CHAR, ROW_RADIX} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		char_t       ch;
		logic        start;
		logic        typed;
		num_result_t want;
	} plan_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	radix_t              cfg_data  = RADIX_RESET;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	char_t               s_tdata   = CH_NUL;
	logic                s_tuser   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	// sideband travelling with each character: a result typed into the table
	logic        row_typed = 1'b0;
	num_result_t row_want  = '0;

	// pacing controls
	logic        calm       = 1'b0;
	int unsigned hold_asked = 0;
	int unsigned hold_seen  = 0;
	int unsigned hold_left  = 0;

	// converter mirror
	radix_t        radix_reg;
	parse_state_t  pstate;
	logic          neg;
	logic          ovf;
	logic [63:0]   acc;
	radix_t        cur_base;
	logic [31:0]   pos;
	logic [31:0]   num_start;

	num_result_t expected_results[$];
	plan_row_t   plan[$];
	char_t       text[$];
	radix_t      radix_plan[$] = '{RADIX_RESET, RADIX_AUTO, RADIX_HEX, RADIX_MIN, RADIX_MAX,
		RADIX_ONE, RADIX_OCT, RADIX_TOP, RADIX_AUTO, RADIX_PAST};

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;

	ascii_to_signed_integer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] character
		.s_tuser   (s_tuser),   // [0] start_req
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // [63:0] value, [95:64] end_offset, [97:96] status
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- mirror

	function automatic num_result_t make_result(input logic [63:0] v, input logic [31:0] off,
		input status_t s);
		num_result_t r;
		r.value  = v;
		r.offset = off;
		r.status = s;
		return r;
	endfunction

	function automatic int unsigned char_digit(input char_t c);
		if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
		if (c >= CH_LC_A && c <= CH_LC_Z) return c - CH_LC_A + 10;
		if (c >= CH_UC_A && c <= CH_UC_Z) return c - CH_UC_A + 10;
		return NOT_A_DIGIT;
	endfunction

	// offset counter saturates instead of wrapping
	function automatic void step_pos();
		if (pos != '1) pos = pos + 1'b1;
	endfunction

	// overflow is sticky: once set the accumulator is frozen
	function automatic void take_digit(input int unsigned d);
		logic [63:0] d64;
		logic [63:0] b64;
		d64 = 64'(d);
		b64 = 64'(cur_base);
		if (!ovf) begin
			if (acc > (UMAX - d64) / b64) ovf = 1'b1;
			else acc = acc * b64 + d64;
		end
		step_pos();
	endfunction

	function automatic void clear_parser();
		radix_reg = RADIX_RESET;
		pstate    = PS_IDLE;
		neg       = 1'b0;
		ovf       = 1'b0;
		acc       = '0;
		cur_base  = RADIX_AUTO;
		pos       = '0;
		num_start = '0;
	endfunction

	// one character through the parser; got is set when it closes a number
	task automatic convert_char(input char_t c, input logic start, output logic got,
		output num_result_t r);
		int unsigned d;
		d   = char_digit(c);
		got = 1'b0;
		r   = '0;
		if (start) begin
			neg       = 1'b0;
			acc       = '0;
			ovf       = 1'b0;
			pos       = '0;
			num_start = '0;
			cur_base  = radix_reg;
			// bad radix answers at once, the character itself is never looked at
			if (cur_base == RADIX_ONE || cur_base > RADIX_MAX) begin
				r      = make_result('0, '0, ST_BAD_BASE);
				got    = 1'b1;
				pstate = PS_IDLE;
				return;
			end
			pstate = PS_SPACE;
		end
		if (pstate == PS_IDLE) return;
		if (pstate == PS_SPACE) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				step_pos();
				return;
			end
			num_start = pos;
			pstate    = PS_FIRST;
			if (c == CH_PLUS || c == CH_MINUS) begin
				neg = (c == CH_MINUS);
				step_pos();
				return;
			end
		end
		if (pstate == PS_FIRST) begin
			if (c == CH_ZERO && (cur_base == RADIX_AUTO || cur_base == RADIX_HEX)) begin
				step_pos();
				pstate = PS_ZERO;
				return;
			end
			if (cur_base == RADIX_AUTO) cur_base = RADIX_DEC;
			if (d < cur_base) begin
				take_digit(d);
				pstate = PS_DIGITS;
				return;
			end
			// no digits: offset sits just past the whitespace, sign or not
			r      = make_result('0, num_start, ST_NO_DIGITS);
			got    = 1'b1;
			pstate = PS_IDLE;
			return;
		end
		if (pstate == PS_ZERO) begin
			if (c == CH_LC_X || c == CH_UC_X) begin
				step_pos();
				pstate = PS_PREFIX;
				return;
			end
			if (cur_base == RADIX_AUTO) cur_base = RADIX_OCT;
			pstate = PS_DIGITS;
		end
		if (pstate == PS_PREFIX) begin
			if (d < 16) begin
				cur_base = RADIX_HEX;
				take_digit(d);
				pstate = PS_DIGITS;
				return;
			end
			// lone zero before the x: offset points at the x
			r      = make_result('0, (pos > 0) ? pos - 1'b1 : '0, ST_OK);
			got    = 1'b1;
			pstate = PS_IDLE;
			return;
		end
		if (cur_base >= RADIX_MIN && d < cur_base) begin
			take_digit(d);
			return;
		end
		got    = 1'b1;
		pstate = PS_IDLE;
		if (neg) begin
			if (ovf || acc > SMAX + 64'd1) r = make_result(SMIN, pos, ST_RANGE);
			else r = make_result(64'd0 - acc, pos, ST_OK);
		end else begin
			if (ovf || acc > SMAX) r = make_result(SMAX, pos, ST_RANGE);
			else r = make_result(acc, pos, ST_OK);
		end
	endtask

	// ---------------------------------------------------------------- checking

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
	endfunction

	// one process sees every transfer: results are checked before the character
	// accepted at the same edge is predicted, which keeps the order right
	always @(posedge clk) begin : monitor
		num_result_t got_res;
		num_result_t want;
		num_result_t predicted;
		logic        produced;
		logic        progress;
		if (!arst_n) begin
			clear_parser();
		end else begin
			progress = 1'b0;
			if (cfg_valid && cfg_ready) begin
				radix_reg = cfg_data;
				progress  = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				progress       = 1'b1;
				got_res.value  = m_tdata[ValueW-1:0];
				got_res.offset = m_tdata[ValueW +: OffsetW];
				got_res.status = m_tdata[ValueW+OffsetW +: StatusW];
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %h offset %0d status %0d",
						got_res.value, got_res.offset, got_res.status));
				end else begin
					want = expected_results.pop_front();
					if (got_res.value !== want.value)
						report_mismatch($sformatf("value expected %h got %h",
							want.value, got_res.value));
					if (got_res.offset !== want.offset)
						report_mismatch($sformatf("end offset expected %0d got %0d",
							want.offset, got_res.offset));
					if (got_res.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, got_res.status));
				end
			end
			if (s_tvalid && s_tready) begin
				progress = 1'b1;
				convert_char(s_tdata, s_tuser, produced, predicted);
				// a typed-in table result stands in place of the mirror's
				if (row_typed) expected_results.push_back(row_want);
				else if (produced) expected_results.push_back(predicted);
			end
			// watchdog on transfers, not on wall time
			if (progress) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_ascii_to_signed_integer: errors");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result side

	// random back-pressure, one long hold-off on request, none in the calm stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------- character side

	task automatic send_char(input char_t c, input logic start, input logic typed,
		input num_result_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= c;
		s_tuser   <= start;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// radix only changes once every result is in and the pipe has settled
	task automatic write_radix(input radix_t r);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void plan_char(input char_t c, input logic st);
		plan_row_t row;
		row.kind  = ROW_CHAR;
		row.ch    = c;
		row.start = st;
		row.typed = 1'b0;
		row.want  = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_end(input char_t c, input logic st, input logic [63:0] v,
		input logic [31:0] off, input status_t s);
		plan_row_t row;
		row.kind  = ROW_CHAR;
		row.ch    = c;
		row.start = st;
		row.typed = 1'b1;
		row.want  = make_result(v, off, s);
		plan.push_back(row);
	endfunction

	function automatic void plan_radix(input radix_t r);
		plan_row_t row;
		row.kind  = ROW_RADIX;
		row.ch    = char_t'(r);
		row.start = 1'b0;
		row.typed = 1'b0;
		row.want  = '0;
		plan.push_back(row);
	endfunction

	function automatic char_t digit_char(input int unsigned d);
		if (d < 10) return char_t'(CH_ZERO + d);
		return char_t'(($urandom_range(1) ? CH_LC_A : CH_UC_A) + d - 10);
	endfunction

	// one well-formed number with random content, sometimes cut short
	function automatic void compose_string(input radix_t r);
		int unsigned eff;
		int unsigned shape;
		int unsigned n;
		int unsigned k;
		logic [63:0] v;
		int unsigned digs[$];
		text.delete();
		repeat ($urandom_range(3)) begin
			k = $urandom_range(6);
			text.push_back(k == 6 ? CH_SPACE : char_t'(CH_TAB + k));
		end
		k = $urandom_range(3);
		if (k == 0) text.push_back(CH_PLUS);
		else if (k == 1) text.push_back(CH_MINUS);
		eff = (r == RADIX_AUTO) ? RADIX_DEC : r;
		if ((r == RADIX_AUTO || r == RADIX_HEX) && $urandom_range(2) == 0) begin
			text.push_back(CH_ZERO);
			if ($urandom_range(3) != 0) begin
				text.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
				eff = RADIX_HEX;
			end else if (r == RADIX_AUTO) begin
				eff = RADIX_OCT;
			end
		end
		shape = $urandom_range(9);
		if (shape == 7) begin
			// range limits, all-ones or a random value, now and then one digit too many
			k = $urandom_range(3);
			if (k == 0) v = SMAX;
			else if (k == 1) v = SMIN;
			else if (k == 2) v = UMAX;
			else v = {$urandom, $urandom};
			do begin
				digs.push_front(32'(v % 64'(eff)));
				v = v / 64'(eff);
			end while (v != 0);
			if ($urandom_range(2) == 0) digs.push_back($urandom_range(eff - 1));
		end else begin
			if (shape == 0) n = 0;
			else if (shape == 8) n = $urandom_range(30, 14);
			else n = $urandom_range(6, 1);
			repeat (n) digs.push_back($urandom_range(eff - 1));
		end
		foreach (digs[i]) text.push_back(digit_char(digs[i]));
		text.push_back($urandom_range(3) == 0 ? CH_NUL : char_t'($urandom_range(255)));
		// broken string: the next start drops it
		if ($urandom_range(6) == 0) begin
			k = $urandom_range(text.size() - 1, 1);
			while (text.size() > k) void'(text.pop_back());
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	initial begin
		int unsigned sent;
		int unsigned n;
		logic        held;
		radix_t      r;
		held = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, radix at its reset value of ten
		plan_char(CH_TOP, 1'b0);                          // ignored while idle
		plan_char(CH_SPACE, 1'b1);
		plan_char(CH_TAB, 1'b0);
		plan_char(CH_CR, 1'b0);
		plan_char(CH_MINUS, 1'b0);
		plan_char(CH_NINE, 1'b0);
		plan_end(CH_NUL, 1'b0, 64'(-9), 32'd5, ST_OK);
		plan_char(CH_PLUS, 1'b1);                          // sign but no digits
		plan_end(CH_LC_Z, 1'b0, '0, '0, ST_NO_DIGITS);
		plan_char(char_t'(CH_ZERO + 1), 1'b1);             // restart in mid-string
		plan_char(char_t'(CH_ZERO + 7), 1'b1);
		plan_end(CH_TOP, 1'b0, 64'd7, 32'd1, ST_OK);
		plan_radix(RADIX_ONE);
		plan_end(CH_UC_A, 1'b1, '0, '0, ST_BAD_BASE);
		plan_radix(RADIX_AUTO);                            // 0x with nothing hex after it
		plan_char(CH_ZERO, 1'b1);
		plan_char(CH_LC_X, 1'b0);
		plan_end(char_t'(CH_LC_A + 6), 1'b0, '0, 32'd1, ST_OK);
		plan_radix(RADIX_MAX);                             // thirteen z's overflow in base 36
		plan_char(CH_UC_Z, 1'b1);
		repeat (12) plan_char(CH_LC_Z, 1'b0);
		plan_end(CH_SPACE, 1'b0, SMAX, 32'd13, ST_RANGE);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_RADIX) write_radix(radix_t'(plan[i].ch));
			else send_char(plan[i].ch, plan[i].start, plan[i].typed, plan[i].want);
		end

		// random phases, one radix each, the last one drawn at random
		radix_plan.push_back(radix_t'($urandom_range(63)));
		foreach (radix_plan[p]) begin
			r = radix_plan[p];
			write_radix(r);
			calm <= (p == 2);
			if (r == RADIX_ONE || r > RADIX_MAX) begin
				repeat (BAD_BASE_ITEMS)
					send_char(char_t'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
			end else begin
				sent = 0;
				while (sent < PHASE_ITEMS) begin
					// one long hold-off on the result side while characters keep coming
					if (p == 1 && !held && sent >= 100) begin
						hold_asked <= hold_asked + 1;
						held = 1'b1;
					end
					if ($urandom_range(9) == 0) begin
						// noise: raw bytes, the odd start among them
						n = $urandom_range(8, 1);
						repeat (n)
							send_char(char_t'($urandom_range(255)), $urandom_range(7) == 0,
								1'b0, '0);
						sent += n;
					end else begin
						compose_string(r);
						foreach (text[i]) send_char(text[i], i == 0, 1'b0, '0);
						sent += text.size();
					end
				end
			end
		end

		// drain: every expected result in, then a quiet wait of DRAIN_CYCLES for strays
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_ascii_to_signed_integer: clean");
		end else begin
			$display("tb_ascii_to_signed_integer: errors");
		end
		$finish;
	end

endmodule
